@@ hw/rtl/gda_pkg.sv @@
// Shared types, status codes and month tables for the date offset pipeline.
`timescale 1ns / 1ps

package gda_pkg;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_BAD_DATE = 2'd1,
        STATUS_RANGE    = 2'd2
    } status_t;

    localparam logic [25:0] JDN_FIRST = 26'd1721426;
    localparam logic [25:0] JDN_LAST  = 26'd5373484;

    typedef struct packed {
        status_t     status;
        logic [22:0] j0;
        logic [22:0] j1;
    } day_pair_t;

    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    function automatic logic [8:0] month_base(input logic [3:0] m);
        logic [8:0] base;
        case (m)
            4'd3:    base = 9'd0;
            4'd4:    base = 9'd31;
            4'd5:    base = 9'd61;
            4'd6:    base = 9'd92;
            4'd7:    base = 9'd122;
            4'd8:    base = 9'd153;
            4'd9:    base = 9'd184;
            4'd10:   base = 9'd214;
            4'd11:   base = 9'd245;
            4'd12:   base = 9'd275;
            4'd1:    base = 9'd306;
            4'd2:    base = 9'd337;
            default: base = 9'd0;
        endcase
        return base;
    endfunction

endpackage

@@ hw/rtl/gregorian_date_add_days.sv @@
// Gregorian date plus signed day offset, streaming top level.
// Usage:
//   Input channel s_*: one item per date, tdata holds year, month, day and a
//   signed day offset. Output channel m_*: one result item per input item,
//   in order, with status, input and result day numbers and the result date.
//   Status 0 is ok, 1 marks an invalid input date, 2 a result outside years
//   1 to 9999; on a non-zero status every other result field is zero.
// Pipeline: three stages check the date, build the day number and add the
//   offset, then seven stages convert the sum back to a date, the last one
//   being the output register.
// Throughput: one item per cycle while the output is not stalled; each stage
//   holds a few constant multiplies and a short add chain.
// Reset: rst_n clears all valid bits at once; the pipeline is empty after.
// Stall: while m_tvalid is high and m_tready low the whole pipeline holds
//   and s_tready drops; nothing is lost or repeated. Bubbles in the pipeline
//   never block acceptance.
`timescale 1ns / 1ps

module gregorian_date_add_days
    import gda_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // in_year[13:0], in_month[17:14], in_day[22:18],
                                   // day_offset[46:23], zero pad[47]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // status[1:0], input_day_number[24:2],
                                   // result_day_number[47:25], out_year[61:48],
                                   // out_month[65:62], out_day[70:66], zero pad[71]
);

    logic        en;
    logic        fwd_valid;
    day_pair_t   fwd_pair;
    status_t     status;
    logic [22:0] input_day_number;
    logic [22:0] result_day_number;
    logic [13:0] out_year;
    logic [3:0]  out_month;
    logic [4:0]  out_day;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    gda_fwd u_fwd (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (s_tvalid),
        .in_year    (s_tdata[13:0]),
        .in_month   (s_tdata[17:14]),
        .in_day     (s_tdata[22:18]),
        .day_offset ($signed(s_tdata[46:23])),
        .out_valid  (fwd_valid),
        .out_pair   (fwd_pair)
    );

    gda_inv u_inv (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .en                    (en),
        .in_valid              (fwd_valid),
        .in_pair               (fwd_pair),
        .out_valid             (m_tvalid),
        .out_status            (status),
        .out_input_day_number  (input_day_number),
        .out_result_day_number (result_day_number),
        .out_year              (out_year),
        .out_month             (out_month),
        .out_day               (out_day)
    );

    assign m_tdata = {1'b0, out_day, out_month, out_year, result_day_number,
                      input_day_number, status};

endmodule

@@ hw/rtl/gda_fwd.sv @@
// Date check, date to day number conversion and offset add, three stages.
`timescale 1ns / 1ps

module gda_fwd
    import gda_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic [13:0]        in_year,
    input  logic [3:0]         in_month,
    input  logic [4:0]         in_day,
    input  logic signed [23:0] day_offset,
    output logic               out_valid,
    output day_pair_t          out_pair
);

    localparam int K100 = 22;
    localparam longint unsigned R100_L = ((64'd1 << K100) + 64'd99) / 64'd100;
    localparam logic [15:0] R100 = 16'(R100_L);

    logic               v1_reg, v2_reg, v3_reg;
    logic [13:0]        y_reg;
    logic [4:0]         d_reg;
    logic signed [23:0] off1_reg, off2_reg;
    logic [7:0]         q100y_reg, q100yy_reg;
    logic [14:0]        yy_reg;
    logic [8:0]         base_reg;
    logic [4:0]         len_reg;
    logic               ymok_reg, feb_reg;
    logic               dok_reg;
    logic [22:0]        j0_reg;
    day_pair_t          pair_reg;

    logic [14:0]        yy_next;
    logic [30:0]        py, pyy;
    logic [13:0]        r100;
    logic               leap;
    logic [4:0]         lim;
    logic               dok_next;
    logic [23:0]        j0_next;
    logic signed [25:0] j1;
    day_pair_t          pair_next;

    always_comb
    begin
        yy_next = 15'(in_year) + 15'd4800 - 15'(in_month <= 4'd2);
        py      = 31'(in_year) * 31'(R100);
        pyy     = 31'(yy_next) * 31'(R100);
    end

    always_comb
    begin
        r100     = y_reg - 14'({6'd0, q100y_reg} * 14'd100);
        leap     = ((y_reg[1:0] == 2'd0) && (r100 != 14'd0)) ||
                   ((r100 == 14'd0) && (q100y_reg[1:0] == 2'd0));
        lim      = (feb_reg && leap) ? 5'd29 : len_reg;
        dok_next = ymok_reg && (d_reg != 5'd0) && (d_reg <= lim);
        j0_next  = {19'd0, d_reg} + {15'd0, base_reg} + 24'({9'd0, yy_reg} * 24'd365)
                 + {11'd0, yy_reg[14:2]} - {16'd0, q100yy_reg}
                 + {18'd0, q100yy_reg[7:2]} - 24'd32045;
    end

    always_comb
    begin
        j1 = $signed({3'b000, j0_reg}) + $signed({{2{off2_reg[23]}}, off2_reg});
        pair_next.j0 = j0_reg;
        pair_next.j1 = j1[22:0];
        if (!dok_reg)
        begin
            pair_next.status = STATUS_BAD_DATE;
        end
        else if ((j1 < $signed(JDN_FIRST)) || (j1 > $signed(JDN_LAST)))
        begin
            pair_next.status = STATUS_RANGE;
        end
        else
        begin
            pair_next.status = STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y_reg      <= in_year;
            d_reg      <= in_day;
            off1_reg   <= day_offset;
            q100y_reg  <= py[29:22];
            yy_reg     <= yy_next;
            q100yy_reg <= pyy[29:22];
            base_reg   <= month_base(in_month);
            len_reg    <= month_len(in_month);
            ymok_reg   <= (in_year != 14'd0) && (in_year <= 14'd9999) &&
                          (in_month != 4'd0) && (in_month <= 4'd12);
            feb_reg    <= (in_month == 4'd2);
            dok_reg    <= dok_next;
            j0_reg     <= j0_next[22:0];
            off2_reg   <= off1_reg;
            pair_reg   <= pair_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_pair  = pair_reg;

endmodule

@@ hw/rtl/gda_inv.sv @@
// Day number to date conversion and result masking, seven stages.
`timescale 1ns / 1ps

module gda_inv
    import gda_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  day_pair_t   in_pair,
    output logic        out_valid,
    output status_t     out_status,
    output logic [22:0] out_input_day_number,
    output logic [22:0] out_result_day_number,
    output logic [13:0] out_year,
    output logic [3:0]  out_month,
    output logic [4:0]  out_day
);

    localparam int K146097 = 44;
    localparam int K1461   = 37;
    localparam int K153    = 19;
    localparam int K5      = 11;
    localparam longint unsigned R146097_L =
        ((64'd1 << K146097) + 64'd146096) / 64'd146097;
    localparam longint unsigned R1461_L = ((64'd1 << K1461) + 64'd1460) / 64'd1461;
    localparam longint unsigned R153_L  = ((64'd1 << K153) + 64'd152) / 64'd153;
    localparam longint unsigned R5_L    = ((64'd1 << K5) + 64'd4) / 64'd5;
    localparam logic [26:0] R146097 = 27'(R146097_L);
    localparam logic [26:0] R1461   = 27'(R1461_L);
    localparam logic [11:0] R153    = 12'(R153_L);
    localparam logic [8:0]  R5      = 9'(R5_L);

    logic [6:0]  v_reg;
    day_pair_t   p1_reg, p2_reg, p3_reg, p4_reg, p5_reg, p6_reg;
    logic [8:0]  c_reg;
    logic [25:0] e2_reg, e3_reg;
    logic [15:0] q1461_3_reg, q1461_4_reg, q1461_5_reg;
    logic [10:0] h4_reg, h5_reg;
    logic [3:0]  q153_reg;
    logic [7:0]  r153_reg;
    logic [3:0]  mon_reg;
    logic [13:0] year6_reg;

    status_t     status_reg;
    logic [22:0] in_dn_reg, res_dn_reg;
    logic [13:0] year_reg;
    logic [3:0]  month_reg;
    logic [4:0]  day_reg;

    logic [25:0] x;
    logic [52:0] prod146;
    logic [10:0] c3;
    logic [23:0] f;
    logic [52:0] prod1461;
    logic [25:0] rem1461;
    logic [8:0]  g;
    logic [10:0] h;
    logic [22:0] prod153;
    logic [10:0] r153;
    logic [4:0]  t;
    logic [4:0]  mon;
    logic [16:0] year17;
    logic [16:0] prod5;
    logic [4:0]  day;
    logic        ok;

    always_comb
    begin
        x        = {1'b0, in_pair.j1, 2'b00} + 26'd274277;
        prod146  = 53'(x) * 53'(R146097);
        c3       = 11'({c_reg, 1'b0}) + 11'(c_reg);
        f        = {1'b0, p1_reg.j1} + 24'd1401 + {15'd0, c3[10:2]} - 24'd38;
        prod1461 = 53'(e2_reg) * 53'(R1461);
        rem1461  = e3_reg - 26'({10'd0, q1461_3_reg} * 26'd1461);
        g        = rem1461[10:2];
        h        = 11'({g, 2'b00}) + 11'(g) + 11'd2;
        prod153  = 23'(h4_reg) * 23'(R153);
        r153     = h5_reg - 11'({7'd0, q153_reg} * 11'd153);
        t        = {1'b0, q153_reg} + 5'd2;
        mon      = ((t >= 5'd12) ? (t - 5'd12) : t) + 5'd1;
        year17   = {1'b0, q1461_5_reg} - 17'd4716 + 17'(mon <= 5'd2);
        prod5    = 17'(r153_reg) * 17'(R5);
        day      = prod5[15:11] + 5'd1;
        ok       = (p6_reg.status == STATUS_OK);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[5:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg      <= in_pair;
            c_reg       <= prod146[52:44];
            p2_reg      <= p1_reg;
            e2_reg      <= {f, 2'b11};
            p3_reg      <= p2_reg;
            e3_reg      <= e2_reg;
            q1461_3_reg <= prod1461[52:37];
            p4_reg      <= p3_reg;
            q1461_4_reg <= q1461_3_reg;
            h4_reg      <= h;
            p5_reg      <= p4_reg;
            q1461_5_reg <= q1461_4_reg;
            h5_reg      <= h4_reg;
            q153_reg    <= prod153[22:19];
            p6_reg      <= p5_reg;
            r153_reg    <= r153[7:0];
            mon_reg     <= mon[3:0];
            year6_reg   <= year17[13:0];
            status_reg  <= p6_reg.status;
            in_dn_reg   <= ok ? p6_reg.j0 : 23'd0;
            res_dn_reg  <= ok ? p6_reg.j1 : 23'd0;
            year_reg    <= ok ? year6_reg : 14'd0;
            month_reg   <= ok ? mon_reg : 4'd0;
            day_reg     <= ok ? day : 5'd0;
        end
    end

    assign out_valid             = v_reg[6];
    assign out_status            = status_reg;
    assign out_input_day_number  = in_dn_reg;
    assign out_result_day_number = res_dn_reg;
    assign out_year              = year_reg;
    assign out_month             = month_reg;
    assign out_day               = day_reg;

endmodule
